// ===== src/text_console_writer_top_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros used by the text console writer sequencer (tcw_seq)
// ---------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_TOP_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define TCW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/tcw_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tcw_pkg
// Types and constants of the text console writer.
// ---------------------------------------------------------------------------
package tcw_pkg;

  localparam int CELL_W = 16;

  localparam logic [7:0] BLANK_CHAR  = 8'h20;
  localparam logic [7:0] RESET_ATTR  = 8'h07;
  localparam logic [7:0] CH_RETURN   = 8'd13;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_LINEFEED = 8'd10;

  localparam logic REG_TEXT_ATTR  = 1'b0;
  localparam logic REG_CURSOR_EN  = 1'b1;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_GOTO  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_READ  = 2'd3
  } tcw_cmd_t;

  typedef struct packed {
    logic [5:0] row_req;
    logic [6:0] col_req;
    logic [7:0] char_code;
    tcw_cmd_t   cmd;
  } tcw_item_t;

  typedef struct packed {
    logic [CELL_W-1:0] rd_cell;
    logic [12:0]       cursor_linear;
    logic [5:0]        cursor_row;
    logic [6:0]        cursor_col;
  } tcw_result_t;

endpackage

// ===== src/tcw_mem.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tcw_mem
// Screen cell memory: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module tcw_mem #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [tcw_pkg::CELL_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [tcw_pkg::CELL_W-1:0] rdata
);

  logic [tcw_pkg::CELL_W-1:0] cells [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      cells[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= cells[raddr];
    end
  end

endmodule

// ===== src/tcw_seq.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tcw_seq
// Command sequencer: cursor, put/goto/read, and the fill and scroll sweeps.
// ---------------------------------------------------------------------------
`include "text_console_writer_top_assert.svh"

module tcw_seq #(
  parameter int COLS = 80,
  parameter int ROWS = 25,
  localparam int AW = $clog2(COLS * ROWS)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  tcw_pkg::tcw_item_t         item,
  input  logic [7:0]                 text_attr,
  output logic                       res_valid,
  input  logic                       out_free,
  output tcw_pkg::tcw_result_t       res,
  output logic                       mem_we,
  output logic [AW-1:0]              mem_waddr,
  output logic [tcw_pkg::CELL_W-1:0] mem_wdata,
  output logic                       mem_re,
  output logic [AW-1:0]              mem_raddr,
  input  logic [tcw_pkg::CELL_W-1:0] mem_rdata
);

  localparam int CELLS = COLS * ROWS;
  localparam int CW    = $clog2(COLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW1   = CW + 1;
  localparam int RW1   = RW + 1;
  localparam logic [CW:0]   COL_LIM    = CW1'(COLS);
  localparam logic [RW:0]   ROW_LIM    = RW1'(ROWS);
  localparam logic [RW-1:0] LAST_ROW   = RW'(ROWS - 1);
  localparam logic [AW-1:0] COLS_A     = AW'(COLS);
  localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
  localparam logic [AW-1:0] SCROLL_END = AW'(CELLS - COLS);

  typedef enum logic [2:0] {
    S_FILL,
    S_IDLE,
    S_EXEC,
    S_SCROLL,
    S_RESP
  } state_t;

  state_t             state;
  logic [CW-1:0]      cur_col;
  logic [RW-1:0]      cur_row;
  logic [AW-1:0]      cur_lin;
  logic [AW-1:0]      idx;
  logic [7:0]         fill_attr;
  logic               fill_resp;
  tcw_pkg::tcw_item_t item_q;
  logic               pend_we;
  logic [AW-1:0]      pend_addr;
  logic               pend_mem;
  logic               rd_ok;

  logic [CW:0]   pc;
  logic [RW:0]   pr;
  logic          scroll_need;
  logic          printable;
  logic          col_ok;
  logic          row_ok;
  logic [AW-1:0] rd_addr;
  logic [CW-1:0] col_next;
  logic [RW-1:0] row_next;
  logic [AW-1:0] lin_next;

  // Cursor step for put
  always_comb begin
    pc        = {1'b0, cur_col};
    pr        = {1'b0, cur_row};
    printable = 1'b0;
    case (item_q.char_code)
      tcw_pkg::CH_RETURN: begin
        pc = '0;
      end
      tcw_pkg::CH_BACKSPACE: begin
        if (cur_col != '0) begin
          pc = pc - CW1'(1);
        end
      end
      tcw_pkg::CH_LINEFEED: begin
        pc = '0;
        pr = pr + RW1'(1);
      end
      default: begin
        printable = 1'b1;
        pc        = pc + CW1'(1);
      end
    endcase
    if (pc >= COL_LIM) begin
      pc = '0;
      pr = pr + RW1'(1);
    end
    scroll_need = (pr >= ROW_LIM);
  end

  assign col_ok  = ({1'b0, item_q.col_req} < 8'(COLS));
  assign row_ok  = ({1'b0, item_q.row_req} < 7'(ROWS));
  assign rd_addr = AW'(item_q.row_req) * COLS_A + AW'(item_q.col_req);

  always_comb begin
    col_next = cur_col;
    row_next = cur_row;
    case (item_q.cmd)
      tcw_pkg::CMD_PUT: begin
        col_next = pc[CW-1:0];
        row_next = scroll_need ? LAST_ROW : pr[RW-1:0];
      end
      tcw_pkg::CMD_GOTO: begin
        if (col_ok) begin
          col_next = CW'(item_q.col_req);
        end
        if (row_ok) begin
          row_next = RW'(item_q.row_req);
        end
      end
      tcw_pkg::CMD_CLEAR: begin
        col_next = '0;
        row_next = '0;
      end
      default: begin
        col_next = cur_col;
        row_next = cur_row;
      end
    endcase
    lin_next = AW'(row_next) * COLS_A + AW'(col_next);
  end

  // Memory port
  always_comb begin
    mem_we    = pend_we;
    mem_waddr = pend_addr;
    mem_wdata = pend_mem ? mem_rdata : {fill_attr, tcw_pkg::BLANK_CHAR};
    if (state == S_FILL) begin
      mem_we    = 1'b1;
      mem_waddr = idx;
      mem_wdata = {fill_attr, tcw_pkg::BLANK_CHAR};
    end else if (state == S_EXEC && item_q.cmd == tcw_pkg::CMD_PUT && printable) begin
      mem_we    = 1'b1;
      mem_waddr = cur_lin;
      mem_wdata = {text_attr, item_q.char_code};
    end
  end

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = rd_addr;
    if (state == S_SCROLL) begin
      mem_re    = (idx < SCROLL_END);
      mem_raddr = idx + COLS_A;
    end else if (state == S_EXEC) begin
      mem_re    = (item_q.cmd == tcw_pkg::CMD_READ) && col_ok && row_ok;
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_RESP);

  always_comb begin
    res.cursor_col    = 7'(cur_col);
    res.cursor_row    = 6'(cur_row);
    res.cursor_linear = 13'(cur_lin);
    res.rd_cell       = rd_ok ? mem_rdata : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_FILL;
      idx       <= '0;
      fill_attr <= tcw_pkg::RESET_ATTR;
      fill_resp <= 1'b0;
      cur_col   <= '0;
      cur_row   <= '0;
      cur_lin   <= '0;
      pend_we   <= 1'b0;
      pend_addr <= '0;
      pend_mem  <= 1'b0;
      rd_ok     <= 1'b0;
    end else begin
      pend_we <= 1'b0;
      case (state)
        S_FILL: begin
          if (idx == LAST_CELL) begin
            idx   <= '0;
            state <= fill_resp ? S_RESP : S_IDLE;
          end else begin
            idx <= idx + AW'(1);
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            item_q <= item;
            state  <= S_EXEC;
          end
        end
        S_EXEC: begin
          cur_col <= col_next;
          cur_row <= row_next;
          cur_lin <= lin_next;
          rd_ok   <= (item_q.cmd == tcw_pkg::CMD_READ) && col_ok && row_ok;
          idx     <= '0;
          state   <= S_RESP;
          if (item_q.cmd == tcw_pkg::CMD_PUT && scroll_need) begin
            fill_attr <= text_attr;
            state     <= S_SCROLL;
          end else if (item_q.cmd == tcw_pkg::CMD_CLEAR) begin
            fill_attr <= text_attr;
            fill_resp <= 1'b1;
            state     <= S_FILL;
          end
        end
        S_SCROLL: begin
          // The write is registered behind its read, in pend_we, pend_addr and pend_mem
          pend_we   <= 1'b1;
          pend_addr <= idx;
          pend_mem  <= (idx < SCROLL_END);
          if (idx == LAST_CELL) begin
            idx   <= '0;
            state <= S_RESP;
          end else begin
            idx <= idx + AW'(1);
          end
        end
        S_RESP: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `TCW_ASSERT_NOW(a_cursor_range, 1'b1, ({1'b0, cur_col} < COL_LIM) && ({1'b0, cur_row} < ROW_LIM), "cursor out of range")
  `TCW_ASSERT_NOW(a_linear_match, state == S_IDLE, cur_lin == AW'(cur_row) * COLS_A + AW'(cur_col), "cursor linear mismatch")
  `TCW_ASSERT_NOW(a_no_rw_clash, mem_we && mem_re, mem_waddr != mem_raddr, "read and write hit the same cell")
  `TCW_ASSERT_NEXT(a_scroll_drain, state == S_SCROLL && idx == LAST_CELL, pend_we && state == S_RESP, "scroll tail write lost")

endmodule

// ===== src/text_console_writer_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// text_console_writer_top
// Text-mode screen writer: cell memory, cursor, config and result register.
// ---------------------------------------------------------------------------
// Flow: put, goto and read pass through S_EXEC and S_RESP and then the result
// register; one command is in work at a time, so a new item is taken only
// after the last one has left the sequencer. A put that scrolls adds a full
// sweep of the cell memory (read and write ports); a clear, a write-only one.
// Reset: synchronous; a blanking pass over every cell follows, with
// s_tready low until it ends (config writes are taken meanwhile).

module text_console_writer_top #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // cmd[1:0], char_code[9:2], col_req[16:10], row_req[22:17], zero[23]
  input  logic [23:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // cursor_col[6:0], cursor_row[12:7], cursor_linear[25:13],
  // read_char[33:26], read_attr[41:34], zero[47:42]
  output logic [47:0] m_tdata,
  // cursor_shown[0]
  output logic        m_tuser,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int CELLS = COLS * ROWS;
  localparam int AW    = $clog2(CELLS);

  logic [7:0]                 attr;
  logic                       cursor_enable;
  tcw_pkg::tcw_item_t         item;
  tcw_pkg::tcw_result_t       res;
  logic                       res_valid;
  logic                       out_free;
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [tcw_pkg::CELL_W-1:0] mem_wdata;
  logic                       mem_re;
  logic [AW-1:0]              mem_raddr;
  logic [tcw_pkg::CELL_W-1:0] mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      attr          <= tcw_pkg::RESET_ATTR;
      cursor_enable <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        tcw_pkg::REG_TEXT_ATTR: begin
          // drop a zero attribute
          if (cfg_data != 8'd0) begin
            attr <= cfg_data;
          end
        end
        tcw_pkg::REG_CURSOR_EN: begin
          cursor_enable <= cfg_data[0];
        end
        default: begin
          attr <= attr;
        end
      endcase
    end
  end

  assign item.cmd       = tcw_pkg::tcw_cmd_t'(s_tdata[1:0]);
  assign item.char_code = s_tdata[9:2];
  assign item.col_req   = s_tdata[16:10];
  assign item.row_req   = s_tdata[22:17];

  assign out_free = !m_tvalid || m_tready;

  tcw_seq #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .item      (item),
    .text_attr (attr),
    .res_valid (res_valid),
    .out_free  (out_free),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  tcw_mem #(
    .DEPTH(CELLS),
    .AW   (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Result register: holds a beat while the sequencer takes the next item
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && out_free) begin
      m_tdata <= {6'd0, res.rd_cell[15:8], res.rd_cell[7:0],
                  cursor_enable ? res.cursor_linear : 13'd0,
                  res.cursor_row, res.cursor_col};
      m_tuser <= cursor_enable;
    end
  end

endmodule

// ===== tb/sv/tb_text_console_writer_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_text_console_writer_top
// Self-checking bench for the text console writer: a queue-fed command
// driver, a shadow screen with its own cursor that predicts every reply, and
// a reply monitor that compares each beat field by field. A short directed
// run covers editing keys, wrap, scroll, goto limits, clear and reads; random
// phases then run under varying attribute and cursor settings.
// ---------------------------------------------------------------------------
module tb_text_console_writer_top;

  localparam int COLS  = 80;
  localparam int ROWS  = 25;
  localparam int CELLS = COLS * ROWS;
  localparam int PHASE_ITEMS = 200;
  localparam int PHASES = 7;
  localparam int STALL_CYCLES = 300;

  typedef struct {
    logic [6:0]  col;
    logic [5:0]  row;
    logic [12:0] linear;
    logic        shown;
    logic [7:0]  rchar;
    logic [7:0]  rattr;
  } console_reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        m_tuser;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [7:0]  cfg_data = '0;

  text_console_writer_top #(.COLS(COLS), .ROWS(ROWS)) i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // shadow screen state
  logic [15:0] shadow_cells [CELLS];
  int          shadow_col;
  int          shadow_row;
  logic [7:0]  shadow_attr;
  logic        shadow_cur_en;

  tcw_pkg::tcw_item_t pending_cmds [$];
  console_reply_t     replies_due [$];
  tcw_pkg::tcw_item_t offer;
  int n_queued = 0;
  int n_accepted = 0;
  int n_err = 0;
  bit calm = 1'b0;
  int stall_requests = 0;
  int stall_served = 0;
  int stall_left = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void blank_rows(int first_row, logic [7:0] attr);
    for (int i = first_row * COLS; i < CELLS; i++)
      shadow_cells[i] = {attr, tcw_pkg::BLANK_CHAR};
  endfunction

  function automatic console_reply_t console_apply(tcw_pkg::tcw_item_t it);
    console_reply_t r;
    int idx;
    r = '{default: '0};
    case (it.cmd)
      tcw_pkg::CMD_PUT: begin
        if (it.char_code == tcw_pkg::CH_RETURN) begin
          shadow_col = 0;
        end else if (it.char_code == tcw_pkg::CH_BACKSPACE) begin
          if (shadow_col != 0) shadow_col--;
        end else if (it.char_code == tcw_pkg::CH_LINEFEED) begin
          shadow_col = 0;
          shadow_row++;
        end else begin
          shadow_cells[shadow_row * COLS + shadow_col] = {shadow_attr, it.char_code};
          shadow_col++;
        end
        if (shadow_col >= COLS) begin
          shadow_col = 0;
          shadow_row++;
        end
        if (shadow_row >= ROWS) begin
          // shift everything up one line, blank the bottom row
          for (int i = 0; i < CELLS - COLS; i++)
            shadow_cells[i] = shadow_cells[i + COLS];
          blank_rows(ROWS - 1, shadow_attr);
          shadow_row = ROWS - 1;
        end
      end
      tcw_pkg::CMD_GOTO: begin
        if (it.col_req < COLS) shadow_col = it.col_req;
        if (it.row_req < ROWS) shadow_row = it.row_req;
      end
      tcw_pkg::CMD_CLEAR: begin
        blank_rows(0, shadow_attr);
        shadow_col = 0;
        shadow_row = 0;
      end
      default: begin
        if (it.col_req < COLS && it.row_req < ROWS) begin
          idx = it.row_req * COLS + it.col_req;
          r.rchar = shadow_cells[idx][7:0];
          r.rattr = shadow_cells[idx][15:8];
        end
      end
    endcase
    r.col    = shadow_col[6:0];
    r.row    = shadow_row[5:0];
    r.linear = shadow_cur_en ? 13'(shadow_row * COLS + shadow_col) : 13'd0;
    r.shown  = shadow_cur_en;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (n_err < 100)
      $display("ERROR @%0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
    n_err++;
  endtask

  task automatic queue_cmd(tcw_pkg::tcw_cmd_t c, logic [7:0] ch, int col, int row);
    tcw_pkg::tcw_item_t it;
    it.cmd       = c;
    it.char_code = ch;
    it.col_req   = col[6:0];
    it.row_req   = row[5:0];
    pending_cmds.push_back(it);
    n_queued++;
  endtask

  task automatic write_reg(logic idx, logic [7:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == tcw_pkg::REG_TEXT_ATTR) begin
      if (val != 8'd0) shadow_attr = val;
    end else begin
      shadow_cur_en = val[0];
    end
  endtask

  task automatic wait_idle();
    while (n_accepted != n_queued || replies_due.size() != 0) @(negedge clk);
  endtask

  task automatic queue_random_cmd();
    int sel;
    int sub;
    sel = $urandom_range(99);
    sub = $urandom_range(99);
    if (sel < 70) begin
      if (sub < 8)
        queue_cmd(tcw_pkg::CMD_PUT, tcw_pkg::CH_LINEFEED, $urandom_range(127),
                  $urandom_range(63));
      else if (sub < 12)
        queue_cmd(tcw_pkg::CMD_PUT, tcw_pkg::CH_RETURN, $urandom_range(127),
                  $urandom_range(63));
      else if (sub < 16)
        queue_cmd(tcw_pkg::CMD_PUT, tcw_pkg::CH_BACKSPACE, $urandom_range(127),
                  $urandom_range(63));
      else
        queue_cmd(tcw_pkg::CMD_PUT, 8'($urandom_range(255)), $urandom_range(127),
                  $urandom_range(63));
    end else if (sel < 84) begin
      if (sub < 80)
        queue_cmd(tcw_pkg::CMD_GOTO, 8'($urandom_range(255)), $urandom_range(COLS - 1),
                  $urandom_range(ROWS - 1));
      else
        queue_cmd(tcw_pkg::CMD_GOTO, 8'($urandom_range(255)), $urandom_range(127),
                  $urandom_range(63));
    end else if (sel < 99) begin
      if (sub < 85)
        queue_cmd(tcw_pkg::CMD_READ, 8'($urandom_range(255)), $urandom_range(COLS - 1),
                  $urandom_range(ROWS - 1));
      else
        queue_cmd(tcw_pkg::CMD_READ, 8'($urandom_range(255)), $urandom_range(127),
                  $urandom_range(63));
    end else begin
      queue_cmd(tcw_pkg::CMD_CLEAR, 8'($urandom_range(255)), $urandom_range(127),
                $urandom_range(63));
    end
  endtask

  // command driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        replies_due.push_back(console_apply(offer));
        n_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_cmds.size() != 0 && (calm || $urandom_range(99) >= 11)) begin
          offer = pending_cmds.pop_front();
          s_tdata  <= {1'b0, offer};
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (rst) begin
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (stall_served != stall_requests) begin
      stall_left   <= STALL_CYCLES;
      stall_served <= stall_requests;
    end
  end

  // reply monitor
  always @(posedge clk) begin
    console_reply_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (replies_due.size() == 0) begin
          report_mismatch("unexpected reply beat", m_tdata[25:0], 0);
        end else begin
          want = replies_due.pop_front();
          if (m_tdata[6:0] != want.col)
            report_mismatch("cursor_col", m_tdata[6:0], want.col);
          if (m_tdata[12:7] != want.row)
            report_mismatch("cursor_row", m_tdata[12:7], want.row);
          if (m_tdata[25:13] != want.linear)
            report_mismatch("cursor_linear", m_tdata[25:13], want.linear);
          if (m_tuser != want.shown)
            report_mismatch("cursor_shown", m_tuser, want.shown);
          if (m_tdata[33:26] != want.rchar)
            report_mismatch("read_char", m_tdata[33:26], want.rchar);
          if (m_tdata[41:34] != want.rattr)
            report_mismatch("read_attr", m_tdata[41:34], want.rattr);
        end
      end
      m_tready <= (stall_left == 0) && (calm || $urandom_range(99) >= 11);
    end
  end

  initial begin
    blank_rows(0, tcw_pkg::RESET_ATTR);
    shadow_col    = 0;
    shadow_row    = 0;
    shadow_attr   = tcw_pkg::RESET_ATTR;
    shadow_cur_en = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // defaults, editing keys, wrap and scroll
    queue_cmd(tcw_pkg::CMD_READ, 8'h00, 0, 0);
    queue_cmd(tcw_pkg::CMD_READ, 8'h00, COLS, 0);
    queue_cmd(tcw_pkg::CMD_READ, 8'hFF, 127, 63);
    queue_cmd(tcw_pkg::CMD_PUT, 8'h41, 0, 0);
    queue_cmd(tcw_pkg::CMD_PUT, 8'hFF, 127, 63);
    queue_cmd(tcw_pkg::CMD_PUT, 8'h00, 0, 0);
    queue_cmd(tcw_pkg::CMD_PUT, tcw_pkg::CH_BACKSPACE, 0, 0);
    queue_cmd(tcw_pkg::CMD_PUT, tcw_pkg::CH_RETURN, 0, 0);
    queue_cmd(tcw_pkg::CMD_PUT, tcw_pkg::CH_BACKSPACE, 0, 0);
    queue_cmd(tcw_pkg::CMD_GOTO, 8'h00, COLS - 1, ROWS - 1);
    queue_cmd(tcw_pkg::CMD_PUT, 8'h5A, 0, 0);
    queue_cmd(tcw_pkg::CMD_GOTO, 8'h00, 5, 0);
    queue_cmd(tcw_pkg::CMD_PUT, tcw_pkg::CH_LINEFEED, 0, 0);
    queue_cmd(tcw_pkg::CMD_GOTO, 8'h00, 100, 3);
    queue_cmd(tcw_pkg::CMD_GOTO, 8'h00, 10, 50);
    queue_cmd(tcw_pkg::CMD_GOTO, 8'h00, 127, 63);
    queue_cmd(tcw_pkg::CMD_READ, 8'h00, 0, 0);
    queue_cmd(tcw_pkg::CMD_READ, 8'h00, COLS - 1, ROWS - 2);
    queue_cmd(tcw_pkg::CMD_GOTO, 8'h00, 0, ROWS - 1);
    queue_cmd(tcw_pkg::CMD_PUT, tcw_pkg::CH_LINEFEED, 0, 0);
    queue_cmd(tcw_pkg::CMD_READ, 8'h00, COLS - 1, ROWS - 3);
    wait_idle();

    // highest attribute, cursor hidden; then clear
    write_reg(tcw_pkg::REG_TEXT_ATTR, 8'hFF);
    write_reg(tcw_pkg::REG_CURSOR_EN, 8'h00);
    queue_cmd(tcw_pkg::CMD_PUT, 8'h7E, 0, 0);
    queue_cmd(tcw_pkg::CMD_CLEAR, 8'h00, 0, 0);
    queue_cmd(tcw_pkg::CMD_READ, 8'h00, COLS - 1, ROWS - 1);
    wait_idle();

    // zero attribute is dropped; lowest attribute
    write_reg(tcw_pkg::REG_TEXT_ATTR, 8'h00);
    write_reg(tcw_pkg::REG_CURSOR_EN, 8'h01);
    queue_cmd(tcw_pkg::CMD_PUT, 8'h31, 0, 0);
    queue_cmd(tcw_pkg::CMD_READ, 8'h00, 0, 0);
    wait_idle();
    write_reg(tcw_pkg::REG_TEXT_ATTR, 8'h01);
    queue_cmd(tcw_pkg::CMD_PUT, 8'h32, 0, 0);
    queue_cmd(tcw_pkg::CMD_READ, 8'h00, 1, 0);
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      if (p == 0)      write_reg(tcw_pkg::REG_TEXT_ATTR, 8'hFF);
      else if (p == 1) write_reg(tcw_pkg::REG_TEXT_ATTR, 8'h01);
      else if (p == 3) write_reg(tcw_pkg::REG_TEXT_ATTR, 8'h00);
      else             write_reg(tcw_pkg::REG_TEXT_ATTR, 8'($urandom_range(1, 255)));
      write_reg(tcw_pkg::REG_CURSOR_EN, (p == 4) ? 8'h00 : 8'($urandom_range(1)));
      calm = (p == 1);
      if (p == 2) stall_requests++;
      for (int n = 0; n < PHASE_ITEMS; n++) queue_random_cmd();
      wait_idle();
    end
    calm = 1'b0;

    repeat (20) @(posedge clk);
    if (n_err == 0)
      $display("text_console_writer_top: match");
    else
      $display("text_console_writer_top: mismatch");
    $finish;
  end

  initial begin
    #200_000_000;
    $display("text_console_writer_top: mismatch");
    $finish;
  end

endmodule
